@@ rtl/aqc_pkg.sv @@
// shared codes, sizes and types for the aabb query classifier
package aqc_pkg;

   localparam int NUM_AXES   = 3;
   localparam int MODE_W     = 2;
   localparam int REL_W      = 2;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // query kinds
   localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BOX    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PLANE  = 2'd3;

   // containment relations
   localparam logic [REL_W-1:0] REL_DISJOINT   = 2'd0;
   localparam logic [REL_W-1:0] REL_CONTAINS   = 2'd1;
   localparam logic [REL_W-1:0] REL_INTERSECTS = 2'd2;

   // plane relations
   localparam logic [REL_W-1:0] REL_FRONT    = 2'd0;
   localparam logic [REL_W-1:0] REL_BACK     = 2'd1;
   localparam logic [REL_W-1:0] REL_STRADDLE = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

   // per-query decisions that travel down the pipeline
   typedef struct packed {
      logic              pt_in;
      logic              bx_dis;
      logic              bx_con;
      logic              sp_con;
      logic              sp_fail;
      logic [MODE_W-1:0] mode;
   } flags_type;

endpackage

@@ rtl/aqc_csr.sv @@
// box bound registers behind the apb-style configuration port
module aqc_csr #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [aqc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [aqc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [aqc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready,
   output logic signed [COORD_WIDTH-1:0]        box_min [aqc_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH-1:0]        box_max [aqc_pkg::NUM_AXES]
);
   import aqc_pkg::*;

   logic signed [COORD_WIDTH-1:0] box_min_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] box_max_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] rd_val;
   logic [REG_IDX_W-1:0]          reg_idx;
   logic                          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            box_min_ff[k] <= '0;
            box_max_ff[k] <= '0;
         end
      end else if (wr_en) begin
         case (reg_idx)
            REG_BOX_MIN_X: box_min_ff[0] <= csr_pwdata[COORD_WIDTH-1:0];
            REG_BOX_MIN_Y: box_min_ff[1] <= csr_pwdata[COORD_WIDTH-1:0];
            REG_BOX_MIN_Z: box_min_ff[2] <= csr_pwdata[COORD_WIDTH-1:0];
            REG_BOX_MAX_X: box_max_ff[0] <= csr_pwdata[COORD_WIDTH-1:0];
            REG_BOX_MAX_Y: box_max_ff[1] <= csr_pwdata[COORD_WIDTH-1:0];
            REG_BOX_MAX_Z: box_max_ff[2] <= csr_pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BOX_MIN_X: rd_val = box_min_ff[0];
         REG_BOX_MIN_Y: rd_val = box_min_ff[1];
         REG_BOX_MIN_Z: rd_val = box_min_ff[2];
         REG_BOX_MAX_X: rd_val = box_max_ff[0];
         REG_BOX_MAX_Y: rd_val = box_max_ff[1];
         REG_BOX_MAX_Z: rd_val = box_max_ff[2];
         default:       rd_val = '0;
      endcase
   end

   // sign-extended read data
   assign csr_prdata = CSR_DATA_W'(rd_val);

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         box_min[k] = box_min_ff[k];
         box_max[k] = box_max_ff[k];
      end
   end

endmodule

@@ rtl/aabb_query_classifier_core.sv @@
// top level: five-stage pipelined query classifier against a configured box
// a query passes through the stage registers a, b, c, d and e before its result shows on rsp_tvalid
// throughput: one query per cycle unless rsp_tready stalls the output; none of the five register stages iterates
// backpressure stalls stage by stage, so a bubble is filled while the output waits
// reset (synchronous, active high) clears all stage valid bits and the box bounds to zero
module aabb_query_classifier_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // query channel
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // tdata: pos_x, pos_y, pos_z, ext_x, ext_y, ext_z, scalar, zero pad
   input  logic [((7*COORD_WIDTH+7)/8)*8-1:0]        req_tdata,
   // tuser: mode
   input  logic [aqc_pkg::MODE_W-1:0]                req_tuser,
   // result channel
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // tdata: relation, hit, zero pad
   output logic [aqc_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   // configuration port
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [aqc_pkg::CSR_ADDR_W-1:0]            csr_paddr,
   input  logic [aqc_pkg::CSR_DATA_W-1:0]            csr_pwdata,
   output logic [aqc_pkg::CSR_DATA_W-1:0]            csr_prdata,
   output logic                                      csr_pready
);
   import aqc_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int SQ_W  = 2 * W;      // square or product of two coordinates
   localparam int SUM_W = 2 * W + 3;  // sum of up to six squares
   localparam int PL_W  = 2 * W + 2;  // three products plus the shifted offset

   // box bounds
   logic signed [W-1:0] box_min [NUM_AXES];
   logic signed [W-1:0] box_max [NUM_AXES];

   aqc_csr #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .box_min     (box_min),
      .box_max     (box_max)
   );

   // stage advance chain: a stage loads when it is empty or the next one moves
   logic adv_a, adv_b, adv_c, adv_d, adv_e;
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;

   assign adv_e = !e_vld_ff || rsp_tready;
   assign adv_d = !d_vld_ff || adv_e;
   assign adv_c = !c_vld_ff || adv_d;
   assign adv_b = !b_vld_ff || adv_c;
   assign adv_a = !a_vld_ff || adv_b;

   assign req_tready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         if (adv_a) a_vld_ff <= req_tvalid;
         if (adv_b) b_vld_ff <= a_vld_ff;
         if (adv_c) c_vld_ff <= b_vld_ff;
         if (adv_d) d_vld_ff <= c_vld_ff;
         if (adv_e) e_vld_ff <= d_vld_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage a: register the query as it arrives
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0]   a_mode_ff;
   logic signed [W-1:0] a_pos_ff [NUM_AXES];
   logic signed [W-1:0] a_ext_ff [NUM_AXES];
   logic signed [W-1:0] a_scl_ff;

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_mode_ff <= req_tuser;
         for (int k = 0; k < NUM_AXES; k++) begin
            a_pos_ff[k] <= req_tdata[k*W +: W];
            a_ext_ff[k] <= req_tdata[(k+NUM_AXES)*W +: W];
         end
         a_scl_ff <= req_tdata[2*NUM_AXES*W +: W];
      end
   end

   // ---------------------------------------------------------------------
   // stage b: per-axis differences, bound compares and plane corner pick
   // ---------------------------------------------------------------------
   logic signed [W:0]     lo_x [NUM_AXES];
   logic signed [W:0]     hi_x [NUM_AXES];
   logic signed [W:0]     c_x  [NUM_AXES];
   logic signed [W:0]     dlo_w [NUM_AXES];   // min minus center
   logic signed [W:0]     dhi_w [NUM_AXES];   // center minus max
   logic signed [W:0]     cml_w [NUM_AXES];   // center minus min
   logic signed [W:0]     hmc_w [NUM_AXES];   // max minus center
   logic signed [W:0]     s_x;
   logic [NUM_AXES-1:0]   below, above;
   logic [NUM_AXES-1:0]   fail_ax, spcon_ax, bxdis_ax, bxcon_ax;

   logic [W-1:0]          b_dlo_in [NUM_AXES];
   logic [W-1:0]          b_dhi_in [NUM_AXES];
   logic signed [W-1:0]   b_near_in [NUM_AXES];
   logic signed [W-1:0]   b_far_in  [NUM_AXES];
   flags_type             b_flg_in;

   logic [W-1:0]          b_dlo_ff [NUM_AXES];
   logic [W-1:0]          b_dhi_ff [NUM_AXES];
   logic signed [W-1:0]   b_near_ff [NUM_AXES];
   logic signed [W-1:0]   b_far_ff  [NUM_AXES];
   logic signed [W-1:0]   b_ext_ff  [NUM_AXES];
   logic [NUM_AXES-1:0]   b_use_hi_ff;
   logic signed [W-1:0]   b_scl_ff;
   flags_type             b_flg_ff;

   assign s_x = {a_scl_ff[W-1], a_scl_ff};

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         lo_x[k]  = {box_min[k][W-1], box_min[k]};
         hi_x[k]  = {box_max[k][W-1], box_max[k]};
         c_x[k]   = {a_pos_ff[k][W-1], a_pos_ff[k]};
         dlo_w[k] = lo_x[k] - c_x[k];
         dhi_w[k] = c_x[k] - hi_x[k];
         cml_w[k] = c_x[k] - lo_x[k];
         hmc_w[k] = hi_x[k] - c_x[k];
         below[k] = a_pos_ff[k] < box_min[k];
         above[k] = a_pos_ff[k] > box_max[k];
         // out-of-range distances are nonnegative and fit w bits unsigned
         b_dlo_in[k] = below[k] ? dlo_w[k][W-1:0] : '0;
         b_dhi_in[k] = above[k] ? dhi_w[k][W-1:0] : '0;
         // early reject: only the low side counts when the center is below
         fail_ax[k]  = below[k] ? (dlo_w[k] > s_x) : (above[k] && (dhi_w[k] > s_x));
         spcon_ax[k] = (cml_w[k] >= s_x) && (hmc_w[k] >= s_x);
         bxdis_ax[k] = (a_ext_ff[k] < box_min[k]) || above[k];
         bxcon_ax[k] = !below[k] && (a_ext_ff[k] <= box_max[k]);
         // nearest and farthest corners along the plane normal
         b_near_in[k] = (a_ext_ff[k] >= 0) ? box_min[k] : box_max[k];
         b_far_in[k]  = (a_ext_ff[k] >= 0) ? box_max[k] : box_min[k];
      end
      b_flg_in.pt_in   = !(|below) && !(|above);
      b_flg_in.bx_dis  = |bxdis_ax;
      b_flg_in.bx_con  = &bxcon_ax;
      b_flg_in.sp_con  = &spcon_ax;
      b_flg_in.sp_fail = |fail_ax;
      b_flg_in.mode    = a_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            b_dlo_ff[k]  <= b_dlo_in[k];
            b_dhi_ff[k]  <= b_dhi_in[k];
            b_near_ff[k] <= b_near_in[k];
            b_far_ff[k]  <= b_far_in[k];
            b_ext_ff[k]  <= a_ext_ff[k];
         end
         b_use_hi_ff <= ~below;
         b_scl_ff    <= a_scl_ff;
         b_flg_ff    <= b_flg_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage c: squares of the outside distances, radius square, dot terms
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0]        c_sq_lo_ff [NUM_AXES];
   logic [SQ_W-1:0]        c_sq_hi_ff [NUM_AXES];
   logic signed [SQ_W-1:0] c_pn_ff [NUM_AXES];
   logic signed [SQ_W-1:0] c_pf_ff [NUM_AXES];
   logic [SQ_W-1:0]        c_r2_ff;
   logic [NUM_AXES-1:0]    c_use_hi_ff;
   logic signed [W-1:0]    c_scl_ff;
   flags_type              c_flg_ff;

   always_ff @(posedge clock) begin
      if (adv_c) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            c_sq_lo_ff[k] <= b_dlo_ff[k] * b_dlo_ff[k];
            c_sq_hi_ff[k] <= b_dhi_ff[k] * b_dhi_ff[k];
            c_pn_ff[k]    <= b_ext_ff[k] * b_near_ff[k];
            c_pf_ff[k]    <= b_ext_ff[k] * b_far_ff[k];
         end
         // square of a signed radius is never negative
         c_r2_ff     <= b_scl_ff * b_scl_ff;
         c_use_hi_ff <= b_use_hi_ff;
         c_scl_ff    <= b_scl_ff;
         c_flg_ff    <= b_flg_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage d: accumulate squared distances and the two plane dot products
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0]       d_acc_in, d_dist_in;
   logic signed [PL_W-1:0] d_dn_in, d_dp_in, dd_w;

   logic [SUM_W-1:0]       d_acc_ff, d_dist_ff;
   logic signed [PL_W-1:0] d_dn_ff, d_dp_ff;
   logic [SQ_W-1:0]        d_r2_ff;
   flags_type              d_flg_ff;

   // plane offset moved to 16 fraction bits
   assign dd_w = {{(PL_W-W){c_scl_ff[W-1]}}, c_scl_ff} <<< 8;

   always_comb begin
      d_acc_in  = '0;
      d_dist_in = '0;
      d_dn_in   = dd_w;
      d_dp_in   = dd_w;
      for (int k = 0; k < NUM_AXES; k++) begin
         // the early-reject sum skips the high side when the center is below
         d_acc_in  = d_acc_in + SUM_W'(c_sq_lo_ff[k])
                   + (c_use_hi_ff[k] ? SUM_W'(c_sq_hi_ff[k]) : '0);
         d_dist_in = d_dist_in + SUM_W'(c_sq_lo_ff[k]) + SUM_W'(c_sq_hi_ff[k]);
         d_dn_in   = d_dn_in + {{(PL_W-SQ_W){c_pn_ff[k][SQ_W-1]}}, c_pn_ff[k]};
         d_dp_in   = d_dp_in + {{(PL_W-SQ_W){c_pf_ff[k][SQ_W-1]}}, c_pf_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv_d) begin
         d_acc_ff  <= d_acc_in;
         d_dist_ff <= d_dist_in;
         d_dn_ff   <= d_dn_in;
         d_dp_ff   <= d_dp_in;
         d_r2_ff   <= c_r2_ff;
         d_flg_ff  <= c_flg_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage e: final compares and mode select into the output register
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0]  r2_x;
   logic [REL_W-1:0]  e_rel_in, e_rel_ff;
   logic              e_hit_in, e_hit_ff;
   logic [MODE_W-1:0] e_mode_ff;

   assign r2_x = {{(SUM_W-SQ_W){1'b0}}, d_r2_ff};

   always_comb begin
      case (d_flg_ff.mode)
         MODE_POINT: begin
            e_rel_in = d_flg_ff.pt_in ? REL_CONTAINS : REL_DISJOINT;
            e_hit_in = d_flg_ff.pt_in;
         end
         MODE_BOX: begin
            if (d_flg_ff.bx_dis)
               e_rel_in = REL_DISJOINT;
            else if (d_flg_ff.bx_con)
               e_rel_in = REL_CONTAINS;
            else
               e_rel_in = REL_INTERSECTS;
            e_hit_in = !d_flg_ff.bx_dis;
         end
         MODE_SPHERE: begin
            if (d_flg_ff.sp_con)
               e_rel_in = REL_CONTAINS;
            else if (!d_flg_ff.sp_fail && (d_acc_ff <= r2_x))
               e_rel_in = REL_INTERSECTS;
            else
               e_rel_in = REL_DISJOINT;
            e_hit_in = d_dist_ff <= r2_x;
         end
         MODE_PLANE: begin
            if (d_dn_ff > 0)
               e_rel_in = REL_FRONT;
            else if (d_dp_ff < 0)
               e_rel_in = REL_BACK;
            else
               e_rel_in = REL_STRADDLE;
            e_hit_in = (d_dn_ff <= 0) && (d_dp_ff >= 0);
         end
         default: begin
            e_rel_in = REL_DISJOINT;
            e_hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv_e) begin
         e_rel_ff  <= e_rel_in;
         e_hit_ff  <= e_hit_in;
         e_mode_ff <= d_flg_ff.mode;
      end
   end

   assign rsp_tvalid = e_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-REL_W-1){1'b0}}, e_hit_ff, e_rel_ff};

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // a full pipeline behind a stalled output takes no new query
   assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && b_vld_ff && c_vld_ff && d_vld_ff && e_vld_ff && !rsp_tready)
      |-> !req_tready)
      else $error("query accepted into a full stalled pipeline");

   // stage d keeps its transaction while it is stalled
   assert property (@(posedge clock) disable iff (reset)
      (d_vld_ff && !adv_e) |=> d_vld_ff)
      else $error("stage d dropped a stalled transaction");

   // relation code never exceeds the intersects code
   assert property (@(posedge clock) disable iff (reset)
      e_vld_ff |-> (e_rel_ff == REL_DISJOINT || e_rel_ff == REL_CONTAINS ||
                    e_rel_ff == REL_INTERSECTS))
      else $error("relation code out of range");

   // box and point queries report a hit exactly when not disjoint
   assert property (@(posedge clock) disable iff (reset)
      (e_vld_ff && (e_mode_ff == MODE_BOX || e_mode_ff == MODE_POINT))
      |-> (e_hit_ff == (e_rel_ff != REL_DISJOINT)))
      else $error("hit disagrees with relation");

endmodule
